>>> src/cbm_pkg.sv
// Package for the cartridge bank mapper core: register decode codes, config
// indexes, mirroring codes and the field layout of both stream channels.
// No dependencies; used by the core and by its port checker.
`timescale 1ns / 1ps

package cbm_pkg;

	// CPU write decode: {address[15:13], address[0]}
	typedef enum logic [3:0] {
		REG_BANK_SELECT = 4'b1000,
		REG_BANK_DATA   = 4'b1001,
		REG_MIRROR      = 4'b1010,
		REG_SAVE_RAM    = 4'b1011,
		REG_IRQ_LATCH   = 4'b1100,
		REG_IRQ_RELOAD  = 4'b1101,
		REG_IRQ_DISABLE = 4'b1110,
		REG_IRQ_ENABLE  = 4'b1111
	} reg_code_t;

	// bank register chosen by bank_select[2:0] on a bank data write
	typedef enum logic [2:0] {
		BANK_PAIR_LO = 3'd0,
		BANK_PAIR_HI = 3'd1,
		BANK_SINGLE0 = 3'd2,
		BANK_SINGLE1 = 3'd3,
		BANK_SINGLE2 = 3'd4,
		BANK_SINGLE3 = 3'd5,
		BANK_PRG_A   = 3'd6,
		BANK_PRG_B   = 3'd7
	} bank_reg_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_PRG_BANK_COUNT = 2'd0,
		CFG_CHR_ROM        = 2'd1,
		CFG_FOUR_SCREEN    = 2'd2,
		CFG_PATCH_MODE     = 2'd3
	} cfg_code_t;

	// IRQ counter decrement variants
	typedef enum logic [1:0] {
		PATCH_POST     = 2'd0,
		PATCH_PRE_ZERO = 2'd1,
		PATCH_PRE_ONE  = 2'd2,
		PATCH_SPARE    = 2'd3
	} patch_t;

	// mirroring codes
	localparam logic [1:0] MIRROR_DEFAULT    = 2'd0;
	localparam logic [1:0] MIRROR_VERTICAL   = 2'd1;
	localparam logic [1:0] MIRROR_HORIZONTAL = 2'd2;

	// command kind carried in tuser
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	// bank-select fields
	localparam int SEL_PRG_SWAP_BIT = 6;
	localparam int SEL_CHR_SWAP_BIT = 7;

	// visible scanlines end here
	localparam logic [8:0] VISIBLE_LINES = 9'd240;

	// reset values of the configuration registers
	localparam logic [8:0] PRG_BANK_COUNT_RESET = 9'd32;

	// field layout
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 104;
	localparam int OUT_CHR_LO  = 32;
	localparam int OUT_MIRROR_LO = 96;
	localparam int OUT_SAVE_BIT  = 98;
	localparam int OUT_IRQ_BIT   = 99;

endpackage

>>> src/cartridge_bank_mapper_with_scanline_irq_core.sv
// Cartridge bank mapper with scanline IRQ counter: decodes CPU writes and
// scanline ticks, reports slot banks, mirroring, save-RAM and IRQ pulse.
// Depends on cbm_pkg.
`timescale 1ns / 1ps
//
//  channel  | direction | payload
//  ---------+-----------+-------------------------------------------------
//  s_axis   | in        | tdata: address, write_data, scanline, render_enabled
//           |           | tuser: command (0 write, 1 tick)
//  m_axis   | out       | tdata: prg_slot_banks, chr_slot_banks, mirror_mode,
//           |           |        save_ram_enabled, irq_pulse
//  cfg      | in        | cfg_index, cfg_data; always ready
//
//  One item per cycle: the mapper state and the result register load at the
//  edge that accepts the item, so its result appears the next cycle.
//  The single result register stalls the input only while it is full and
//  not being taken. arst_n clears the mapper state to its power-on banks.
//  chr_rom_present is accepted but ignored: the core holds no register for
//  it, and its power-on character banks are those for ROM present.

module cartridge_bank_mapper_with_scanline_irq_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// input stream
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// [15:0] address, [23:16] write_data, [32:24] scanline,
	// [33] render_enabled, [39:34] zero
	input  logic [cbm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// [0] command
	input  logic                            s_axis_tuser,
	// result stream
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [31:0] prg_slot_banks, [95:32] chr_slot_banks, [97:96] mirror_mode,
	// [98] save_ram_enabled, [99] irq_pulse, [103:100] zero
	output logic [cbm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// configuration writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [1:0]                      cfg_index,
	input  logic [8:0]                      cfg_data
);

	import cbm_pkg::*;

	typedef struct packed {
		logic [7:0]      bank_select;
		logic [7:0]      prg_bank_a;
		logic [7:0]      prg_bank_b;
		logic [7:0]      chr_pair_low;
		logic [7:0]      chr_pair_high;
		logic [3:0][7:0] chr_single;
		logic [1:0]      mirror;
		logic            save_ram;
		logic [7:0]      irq_reload;
		logic [7:0]      irq_count;
		logic            irq_on;
		logic            reload_armed;
		logic            latch_pending;
	} map_state_t;

	// configuration
	logic [8:0] prg_bank_count_q;
	logic       four_screen_q;
	patch_t     patch_mode_q;

	map_state_t st_q;
	map_state_t st_nxt;
	logic       pulse;

	// input field views
	logic [15:0] in_address;
	logic [7:0]  in_data;
	logic [8:0]  in_scanline;
	logic        in_render;
	reg_code_t   code;

	logic        s_fire;
	logic [7:0]  dec_count;
	logic        tick_live;
	logic        hit;

	logic [7:0]       second_last;
	logic [7:0]       last;
	logic [8:0]       sum_second;
	logic [8:0]       sum_last;
	logic [3:0][7:0]  prg_slot;
	logic [3:0][7:0]  pairs;
	logic [7:0][7:0]  chr_slot;

	logic                   m_valid_q;
	logic [OUT_TDATA_W-1:0] m_data_q;

	assign in_address  = s_axis_tdata[15:0];
	assign in_data     = s_axis_tdata[23:16];
	assign in_scanline = s_axis_tdata[32:24];
	assign in_render   = s_axis_tdata[33];
	assign code        = reg_code_t'({in_address[15:13], in_address[0]});

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !m_valid_q || m_axis_tready;
	assign s_fire        = s_axis_tvalid && s_axis_tready;

	// hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_bank_count_q <= PRG_BANK_COUNT_RESET;
			four_screen_q    <= 1'b0;
			patch_mode_q     <= PATCH_POST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_code_t'(cfg_index))
				CFG_PRG_BANK_COUNT: prg_bank_count_q <= cfg_data;
				CFG_FOUR_SCREEN:    four_screen_q    <= cfg_data[0];
				CFG_PATCH_MODE:     patch_mode_q     <= patch_t'(cfg_data[1:0]);
				default: ;
			endcase
		end
	end

	// scanline counter step
	always_comb begin
		dec_count = st_q.irq_count - 8'd1;
		tick_live = st_q.irq_on && (in_scanline < VISIBLE_LINES) && in_render;
		case (patch_mode_q)
			PATCH_PRE_ZERO: hit = (dec_count == 8'd0);
			PATCH_PRE_ONE:  hit = (dec_count <= 8'd1);
			default:        hit = (st_q.irq_count == 8'd0);
		endcase
	end

	// next mapper state for the item on the input
	always_comb begin
		st_nxt = st_q;
		pulse  = 1'b0;
		if (s_axis_tuser == CMD_TICK) begin
			if (tick_live) begin
				st_nxt.reload_armed = 1'b0;
				st_nxt.irq_count    = hit ? st_q.irq_reload : dec_count;
				pulse               = hit;
			end
		end else begin
			unique case (code)
				REG_BANK_SELECT: st_nxt.bank_select = in_data;
				REG_BANK_DATA: begin
					unique case (bank_reg_t'(st_q.bank_select[2:0]))
						BANK_PAIR_LO: st_nxt.chr_pair_low  = {in_data[7:1], 1'b0};
						BANK_PAIR_HI: st_nxt.chr_pair_high = {in_data[7:1], 1'b0};
						BANK_SINGLE0: st_nxt.chr_single[0] = in_data;
						BANK_SINGLE1: st_nxt.chr_single[1] = in_data;
						BANK_SINGLE2: st_nxt.chr_single[2] = in_data;
						BANK_SINGLE3: st_nxt.chr_single[3] = in_data;
						BANK_PRG_A:   st_nxt.prg_bank_a    = in_data;
						BANK_PRG_B:   st_nxt.prg_bank_b    = in_data;
					endcase
				end
				REG_MIRROR: begin
					if (!four_screen_q) begin
						st_nxt.mirror = in_data[0] ? MIRROR_HORIZONTAL : MIRROR_VERTICAL;
					end
				end
				REG_SAVE_RAM: st_nxt.save_ram = in_data[7];
				REG_IRQ_LATCH: begin
					st_nxt.irq_reload    = in_data;
					st_nxt.latch_pending = !st_q.reload_armed;
					if (st_q.reload_armed) begin
						st_nxt.irq_count = in_data;
					end
				end
				REG_IRQ_RELOAD: st_nxt.irq_count = st_q.irq_reload;
				REG_IRQ_DISABLE: begin
					st_nxt.irq_on       = 1'b0;
					st_nxt.reload_armed = 1'b1;
				end
				REG_IRQ_ENABLE: begin
					st_nxt.irq_on = 1'b1;
					if (st_q.latch_pending) begin
						st_nxt.irq_count = st_q.irq_reload;
					end
				end
				// addresses below the mapper window change nothing
				default: ;
			endcase
		end
	end

	// slot layout from the updated state
	always_comb begin
		sum_second  = prg_bank_count_q - 9'd2;
		sum_last    = prg_bank_count_q - 9'd1;
		second_last = sum_second[7:0];
		last        = sum_last[7:0];
		prg_slot[0] = st_nxt.bank_select[SEL_PRG_SWAP_BIT] ? second_last : st_nxt.prg_bank_a;
		prg_slot[1] = st_nxt.prg_bank_b;
		prg_slot[2] = st_nxt.bank_select[SEL_PRG_SWAP_BIT] ? st_nxt.prg_bank_a : second_last;
		prg_slot[3] = last;
		pairs[0] = st_nxt.chr_pair_low;
		pairs[1] = st_nxt.chr_pair_low + 8'd1;
		pairs[2] = st_nxt.chr_pair_high;
		pairs[3] = st_nxt.chr_pair_high + 8'd1;
		for (int i = 0; i < 4; i++) begin
			if (st_nxt.bank_select[SEL_CHR_SWAP_BIT]) begin
				chr_slot[i]     = st_nxt.chr_single[i];
				chr_slot[i + 4] = pairs[i];
			end else begin
				chr_slot[i]     = pairs[i];
				chr_slot[i + 4] = st_nxt.chr_single[i];
			end
		end
	end

	// advance mapper state on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.bank_select   <= 8'd0;
			st_q.prg_bank_a    <= 8'd0;
			st_q.prg_bank_b    <= 8'd1;
			st_q.chr_pair_low  <= 8'd0;
			st_q.chr_pair_high <= 8'd2;
			st_q.chr_single[0] <= 8'd4;
			st_q.chr_single[1] <= 8'd5;
			st_q.chr_single[2] <= 8'd6;
			st_q.chr_single[3] <= 8'd7;
			st_q.mirror        <= MIRROR_DEFAULT;
			st_q.save_ram      <= 1'b0;
			st_q.irq_reload    <= 8'd0;
			st_q.irq_count     <= 8'd0;
			st_q.irq_on        <= 1'b0;
			st_q.reload_armed  <= 1'b0;
			st_q.latch_pending <= 1'b0;
		end else if (s_fire) begin
			st_q <= st_nxt;
		end
	end

	// result register: load on accept, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s_fire) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			m_data_q <= {4'd0, pulse, st_nxt.save_ram, st_nxt.mirror, chr_slot, prg_slot};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

>>> src/cbm_checker.sv
// Port-level checker for the cartridge bank mapper core, with its bind.
// Depends on cbm_pkg and cartridge_bank_mapper_with_scanline_irq_core.
`timescale 1ns / 1ps

module cbm_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            s_axis_tuser,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [cbm_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	import cbm_pkg::*;

	// hold a stalled result transaction
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// input stalls only behind a full, stalled result register
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without back-pressure");

	// every accepted item produces a result next cycle
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
		else $error("accepted item gave no result");

	// register writes never pulse the interrupt
	a_write_no_irq: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_WRITE
		|=> !m_axis_tdata[OUT_IRQ_BIT])
		else $error("irq pulse on a register write");

	// mirroring code stays in its range
	a_mirror: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OUT_MIRROR_LO +: 2] != 2'd3)
		else $error("mirroring code out of range");

endmodule

bind cartridge_bank_mapper_with_scanline_irq_core cbm_checker u_cbm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

>>> test/cartridge_bank_mapper_with_scanline_irq_core_tb.sv
// Testbench for cartridge_bank_mapper_with_scanline_irq_core: directed rows, then random
// CPU writes and scanline ticks under several configurations, checked against a local model.
// Depends on cbm_pkg and the core.
`timescale 1ns / 1ps

module cartridge_bank_mapper_with_scanline_irq_core_tb;
	import cbm_pkg::*;

	typedef struct packed {
		logic        cmd;
		logic [15:0] addr;
		logic [7:0]  wdata;
		logic [8:0]  line;
		logic        render;
	} mapper_in_t;

	typedef struct packed {
		logic        irq;
		logic        save;
		logic [1:0]  mirror;
		logic [63:0] chr;
		logic [31:0] prg;
	} mapper_out_t;

	typedef struct packed {
		mapper_in_t  item;
		logic        typed;
		mapper_out_t want;
	} stim_row_t;

	localparam int N_DIRECTED = 26;
	localparam int PHASE_ITEMS = 200;
	localparam int N_PHASES = 8;
	localparam int LONG_HOLD = 400;

	// banks straight after reset, and with both swap bits set
	localparam mapper_out_t RESET_OUT = '{irq: 1'b0, save: 1'b0, mirror: MIRROR_DEFAULT,
		chr: 64'h0706050403020100, prg: 32'h1F1E0100};
	localparam mapper_out_t SWAP_OUT = '{irq: 1'b0, save: 1'b0, mirror: MIRROR_DEFAULT,
		chr: 64'h0302010007060504, prg: 32'h1F00011E};

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [1:0]             cfg_index;
	logic [8:0]             cfg_data;

	// configuration shadow
	logic [8:0] cfg_banks;
	logic       cfg_chr_rom;
	logic       cfg_four;
	patch_t     cfg_patch;

	// mapper state shadow
	logic [7:0] sel_q, prg_a_q, prg_b_q, pair_lo_q, pair_hi_q;
	logic [7:0] single_q [4];
	logic [1:0] mirror_q;
	logic       save_q;
	logic [7:0] irq_latch_q, irq_count_q;
	logic       irq_on_q, reload_armed_q, latch_pending_q;

	mapper_out_t banks_due [$];
	int          mismatches = 0;
	bit          steady;
	bit          hold_req;

	stim_row_t   directed_rows [N_DIRECTED];

	cartridge_bank_mapper_with_scanline_irq_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// load power-on state; the character banks depend on ROM presence at reset
	function automatic void reset_mapper();
		cfg_banks = PRG_BANK_COUNT_RESET;
		cfg_chr_rom = 1'b1;
		cfg_four = 1'b0;
		cfg_patch = PATCH_POST;
		sel_q = 8'd0;
		prg_a_q = 8'd0;
		prg_b_q = 8'd1;
		pair_lo_q = cfg_chr_rom ? 8'd0 : 8'd0;
		pair_hi_q = cfg_chr_rom ? 8'd2 : 8'd0;
		for (int i = 0; i < 4; i++)
			single_q[i] = cfg_chr_rom ? 8'(4 + i) : 8'd0;
		mirror_q = MIRROR_DEFAULT;
		save_q = 1'b0;
		irq_latch_q = 8'd0;
		irq_count_q = 8'd0;
		irq_on_q = 1'b0;
		reload_armed_q = 1'b0;
		latch_pending_q = 1'b0;
	endfunction

	// advance the mapper state by one item and return the banks it reports
	function automatic mapper_out_t step_mapper(mapper_in_t it);
		mapper_out_t res;
		reg_code_t code;
		logic hit;
		logic [8:0] second_last, last_bank;
		logic [3:0][7:0] prg_w, pair_w, single_w;
		res = '0;
		code = reg_code_t'({it.addr[15:13], it.addr[0]});
		if (it.cmd == CMD_TICK) begin
			if (irq_on_q && it.line < VISIBLE_LINES && it.render) begin
				reload_armed_q = 1'b0;
				case (cfg_patch)
					PATCH_PRE_ZERO: begin
						irq_count_q = irq_count_q - 8'd1;
						hit = (irq_count_q == 8'd0);
					end
					PATCH_PRE_ONE: begin
						irq_count_q = irq_count_q - 8'd1;
						hit = (irq_count_q <= 8'd1);
					end
					default: begin
						hit = (irq_count_q == 8'd0);
						irq_count_q = irq_count_q - 8'd1;
					end
				endcase
				if (hit) begin
					irq_count_q = irq_latch_q;
					res.irq = 1'b1;
				end
			end
		end else if (it.addr[15]) begin
			case (code)
				REG_BANK_SELECT: sel_q = it.wdata;
				REG_BANK_DATA: begin
					case (bank_reg_t'(sel_q[2:0]))
						BANK_PAIR_LO: pair_lo_q = it.wdata & 8'hFE;
						BANK_PAIR_HI: pair_hi_q = it.wdata & 8'hFE;
						BANK_PRG_A:   prg_a_q = it.wdata;
						BANK_PRG_B:   prg_b_q = it.wdata;
						default:      single_q[2'(sel_q[2:0] - 3'd2)] = it.wdata;
					endcase
				end
				REG_MIRROR: begin
					if (!cfg_four)
						mirror_q = it.wdata[0] ? MIRROR_HORIZONTAL : MIRROR_VERTICAL;
				end
				REG_SAVE_RAM: save_q = it.wdata[7];
				REG_IRQ_LATCH: begin
					irq_latch_q = it.wdata;
					latch_pending_q = ~reload_armed_q;
					if (reload_armed_q)
						irq_count_q = it.wdata;
				end
				REG_IRQ_RELOAD: irq_count_q = irq_latch_q;
				REG_IRQ_DISABLE: begin
					irq_on_q = 1'b0;
					reload_armed_q = 1'b1;
				end
				REG_IRQ_ENABLE: begin
					irq_on_q = 1'b1;
					if (latch_pending_q)
						irq_count_q = irq_latch_q;
				end
				default: ;
			endcase
		end

		// arrange slots by the two swap bits
		second_last = cfg_banks - 9'd2;
		last_bank = cfg_banks - 9'd1;
		prg_w[0] = sel_q[SEL_PRG_SWAP_BIT] ? second_last[7:0] : prg_a_q;
		prg_w[1] = prg_b_q;
		prg_w[2] = sel_q[SEL_PRG_SWAP_BIT] ? prg_a_q : second_last[7:0];
		prg_w[3] = last_bank[7:0];
		pair_w = {pair_hi_q + 8'd1, pair_hi_q, pair_lo_q + 8'd1, pair_lo_q};
		for (int i = 0; i < 4; i++)
			single_w[i] = single_q[i];
		res.prg = prg_w;
		res.chr = sel_q[SEL_CHR_SWAP_BIT] ? {pair_w, single_w} : {single_w, pair_w};
		res.mirror = mirror_q;
		res.save = save_q;
		return res;
	endfunction

	function automatic stim_row_t wr_row(logic [15:0] addr, logic [7:0] wdata);
		stim_row_t r;
		r = '0;
		r.item.cmd = CMD_WRITE;
		r.item.addr = addr;
		r.item.wdata = wdata;
		return r;
	endfunction

	function automatic stim_row_t tick_row(logic [8:0] line, logic render);
		stim_row_t r;
		r = '0;
		r.item.cmd = CMD_TICK;
		r.item.line = line;
		r.item.render = render;
		return r;
	endfunction

	// mostly well-formed register writes and visible-line ticks, a little noise
	function automatic mapper_in_t random_item();
		mapper_in_t it;
		reg_code_t code;
		int pick;
		it.addr = 16'($urandom);
		it.wdata = 8'($urandom);
		it.line = 9'($urandom);
		it.render = 1'($urandom);
		it.cmd = CMD_WRITE;
		pick = $urandom_range(0, 99);
		if (pick < 38) begin
			it.cmd = CMD_TICK;
			it.line = ($urandom_range(0, 6) != 0) ? 9'($urandom_range(0, 239))
				: 9'($urandom_range(240, 511));
			it.render = ($urandom_range(0, 9) != 0);
		end else if (pick >= 42) begin
			case ($urandom_range(0, 11))
				0, 1:    code = REG_BANK_SELECT;
				2, 3, 4: code = REG_BANK_DATA;
				5:       code = REG_MIRROR;
				6:       code = REG_SAVE_RAM;
				7:       code = REG_IRQ_LATCH;
				8:       code = REG_IRQ_RELOAD;
				9:       code = REG_IRQ_DISABLE;
				default: code = REG_IRQ_ENABLE;
			endcase
			it.addr[15:13] = code[3:1];
			it.addr[0] = code[0];
			if (code == REG_IRQ_LATCH && $urandom_range(0, 1) == 1)
				it.wdata = 8'($urandom_range(0, 7));
		end
		return it;
	endfunction

	// offer one item from a falling edge, hold it until a transaction, return at a falling edge
	task automatic send_item(mapper_in_t it, logic typed, mapper_out_t want);
		mapper_out_t got;
		if (!steady && $urandom_range(0, 7) == 0) begin
			s_axis_tvalid = 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser = it.cmd;
		s_axis_tdata = {6'd0, it.render, it.line, it.wdata, it.addr};
		do @(posedge clk); while (!s_axis_tready);
		got = step_mapper(it);
		banks_due.push_back(typed ? want : got);
		@(negedge clk);
	endtask

	task automatic write_cfg(cfg_code_t idx, logic [8:0] value);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_PRG_BANK_COUNT: cfg_banks = value;
			CFG_CHR_ROM:        cfg_chr_rom = value[0];
			CFG_FOUR_SCREEN:    cfg_four = value[0];
			CFG_PATCH_MODE:     cfg_patch = patch_t'(value[1:0]);
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// drop valid and hold until every result has come back
	task automatic drain();
		s_axis_tvalid = 1'b0;
		while (banks_due.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	// receiver: random stalls, one long hold-off on request, none in the steady tail
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				m_axis_tready = 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end else if (!steady && $urandom_range(0, 7) == 0) begin
				m_axis_tready = 1'b0;
				repeat ($urandom_range(1, 13)) @(negedge clk);
			end
			m_axis_tready = 1'b1;
		end
	end

	// compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		mapper_out_t want;
		mapper_out_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.prg = m_axis_tdata[31:0];
			got.chr = m_axis_tdata[OUT_CHR_LO +: 64];
			got.mirror = m_axis_tdata[OUT_MIRROR_LO +: 2];
			got.save = m_axis_tdata[OUT_SAVE_BIT];
			got.irq = m_axis_tdata[OUT_IRQ_BIT];
			if (banks_due.size() == 0) begin
				$error("result with no item outstanding: %h", m_axis_tdata);
				mismatches++;
			end else begin
				want = banks_due.pop_front();
				if (got.prg !== want.prg) begin
					$error("prg_slot_banks: expected %h, got %h", want.prg, got.prg);
					mismatches++;
				end
				if (got.chr !== want.chr) begin
					$error("chr_slot_banks: expected %h, got %h", want.chr, got.chr);
					mismatches++;
				end
				if (got.mirror !== want.mirror) begin
					$error("mirror_mode: expected %0d, got %0d", want.mirror, got.mirror);
					mismatches++;
				end
				if (got.save !== want.save) begin
					$error("save_ram_enabled: expected %0d, got %0d", want.save, got.save);
					mismatches++;
				end
				if (got.irq !== want.irq) begin
					$error("irq_pulse: expected %0d, got %0d", want.irq, got.irq);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#1_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		logic [8:0] phase_cfg [N_PHASES][4];
		steady = 1'b0;
		hold_req = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tuser = CMD_WRITE;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_PRG_BANK_COUNT;
		cfg_data = '0;
		reset_mapper();

		// directed rows, run under the reset configuration
		directed_rows[0] = tick_row(9'd0, 1'b1);
		directed_rows[0].typed = 1'b1;
		directed_rows[0].want = RESET_OUT;
		directed_rows[1] = wr_row(16'h8000, 8'hC0);
		directed_rows[1].typed = 1'b1;
		directed_rows[1].want = SWAP_OUT;
		directed_rows[2] = wr_row(16'h8001, 8'hFF);
		directed_rows[3] = wr_row(16'h9FFE, 8'h01);
		directed_rows[4] = wr_row(16'h8001, 8'h81);
		directed_rows[5] = wr_row(16'h8000, 8'h05);
		directed_rows[6] = wr_row(16'h9FFF, 8'h33);
		directed_rows[7] = wr_row(16'h8000, 8'h46);
		directed_rows[8] = wr_row(16'h8001, 8'hFF);
		directed_rows[9] = wr_row(16'h8000, 8'h87);
		directed_rows[10] = wr_row(16'h8001, 8'h00);
		directed_rows[11] = wr_row(16'hA000, 8'h00);
		directed_rows[12] = wr_row(16'hA001, 8'h80);
		directed_rows[13] = wr_row(16'hBFFE, 8'h01);
		directed_rows[14] = wr_row(16'h0000, 8'hFF);
		directed_rows[15] = wr_row(16'h7FFF, 8'h00);
		directed_rows[16] = wr_row(16'hC000, 8'h01);
		directed_rows[17] = wr_row(16'hC001, 8'h00);
		directed_rows[18] = wr_row(16'hFFFF, 8'h00);
		directed_rows[19] = tick_row(9'd0, 1'b1);
		directed_rows[20] = tick_row(9'd239, 1'b1);
		directed_rows[21] = tick_row(9'd240, 1'b1);
		directed_rows[22] = tick_row(9'd511, 1'b1);
		directed_rows[23] = tick_row(9'd100, 1'b0);
		directed_rows[24] = wr_row(16'hE000, 8'h00);
		directed_rows[25] = tick_row(9'd0, 1'b1);

		// bank count, ROM present, four-screen, patch mode per random phase
		phase_cfg[0] = '{9'd2, 9'd0, 9'd1, 9'(PATCH_PRE_ZERO)};
		phase_cfg[1] = '{9'd256, 9'd1, 9'd0, 9'(PATCH_PRE_ONE)};
		phase_cfg[2] = '{9'd0, 9'd0, 9'd0, 9'(PATCH_SPARE)};
		phase_cfg[3] = '{9'd1, 9'd1, 9'd1, 9'(PATCH_POST)};
		phase_cfg[4] = '{9'd511, 9'd0, 9'd0, 9'(PATCH_PRE_ZERO)};
		phase_cfg[5] = '{9'($urandom_range(2, 256)), 9'($urandom_range(0, 1)),
			9'($urandom_range(0, 1)), 9'($urandom_range(0, 2))};
		phase_cfg[6] = '{9'($urandom_range(2, 256)), 9'($urandom_range(0, 1)),
			9'($urandom_range(0, 1)), 9'($urandom_range(0, 2))};
		phase_cfg[7] = '{PRG_BANK_COUNT_RESET, 9'd1, 9'd0, 9'(PATCH_POST)};

		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

		for (int p = 0; p < N_PHASES; p++) begin
			drain();
			write_cfg(CFG_PRG_BANK_COUNT, phase_cfg[p][0]);
			write_cfg(CFG_CHR_ROM, phase_cfg[p][1]);
			write_cfg(CFG_FOUR_SCREEN, phase_cfg[p][2]);
			write_cfg(CFG_PATCH_MODE, phase_cfg[p][3]);
			// stall the result side long enough to back up the input
			if (p == 1)
				hold_req = 1'b1;
			if (p == N_PHASES - 1)
				steady = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_item(random_item(), 1'b0, '0);
		end
		drain();
		repeat (10) @(negedge clk);

		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
